FILE: rtl/aes_pkg.sv
// Package with the AES types, S-box tables and GF(2^8) helper functions.
package aes_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam int unsigned NR = 10;

    localparam logic [1:0] CFG_KEY_HI = 2'd0;
    localparam logic [1:0] CFG_KEY_LO = 2'd1;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    // Forward S-box computed as a constant function: inverse, then affine map.
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] p;
        inv = 8'h00;
        // Brute-force inverse; folds to a constant table in synthesis.
        for (int c = 1; c < 256; c++) begin
            a = x;
            b = c[7:0];
            p = 8'h00;
            for (int i = 0; i < 8; i++) begin
                if (b[0]) p = p ^ a;
                a = xtime(a);
                b = {1'b0, b[7:1]};
            end
            if (p == 8'h01) inv = c[7:0];
        end
        sbox_calc = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    typedef logic [7:0] sbox_arr_t [256];

    function automatic sbox_arr_t gen_fwd();
        sbox_arr_t t;
        for (int i = 0; i < 256; i++) t[i] = sbox_calc(i[7:0]);
        return t;
    endfunction

    function automatic sbox_arr_t gen_inv();
        sbox_arr_t t;
        sbox_arr_t f;
        f = gen_fwd();
        for (int i = 0; i < 256; i++) t[f[i]] = i[7:0];
        return t;
    endfunction

    localparam sbox_arr_t FWD_SBOX = gen_fwd();
    localparam sbox_arr_t SBOX_REV = gen_inv();

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
                    FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // Control bundle from sequencer to round unit.
    typedef struct packed {
        logic load;
        logic step;
        logic dec;
        logic last;
    } rnd_ctrl_t;

endpackage

FILE: rtl/aes128_block_cipher.sv
// Top level of the iterative AES-128 encrypt/decrypt core.
// The key add happens at the input beat; then 10 rounds run, one per cycle
// through one shared round unit, before m_valid rises.
// A new block is taken only once the last result beat has gone; s_ready is
// low while a block is in work and while its result beat waits.
// Key writes re-run the expansion, which holds s_ready low while it runs.
// Synchronous active-low reset loads the all-zero key and expands it.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_text_in_hi,
    input  logic [63:0] s_text_in_lo,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_text_out_hi,
    output logic [63:0] m_text_out_lo
);

    state_t       state_reg, state_next;
    logic [63:0]  key_hi_reg, key_lo_reg;
    logic         kick_reg;
    logic         dec_reg;
    logic [3:0]   rnd_reg, rnd_next;
    logic [3:0]   rd_idx;
    logic [127:0] rd_key;
    logic [127:0] state_out;
    logic         ks_busy;
    rnd_ctrl_t    ctrl;
    logic         accept;

    // Key registers; any write to a key half schedules a fresh expansion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            kick_reg   <= 1'b1;
        end else begin
            kick_reg <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY_HI: begin
                        key_hi_reg <= cfg_data;
                        kick_reg   <= 1'b1;
                    end
                    CFG_KEY_LO: begin
                        key_lo_reg <= cfg_data;
                        kick_reg   <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    aes_key_sched u_ks (
        .aclk   (aclk),
        .start  (kick_reg),
        .key    ({key_hi_reg, key_lo_reg}),
        .rd_idx (rd_idx),
        .rd_key (rd_key),
        .busy   (ks_busy)
    );

    assign s_ready = (state_reg == ST_IDLE) && !ks_busy && !kick_reg;
    assign accept  = s_valid && s_ready;

    // Round counter: encryption reads keys upward, decryption downward.
    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        ctrl       = '0;
        ctrl.dec   = dec_reg;
        rd_idx     = rnd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rd_idx    = s_op ? 4'(NR) : 4'd0;
                ctrl.dec  = s_op;
                ctrl.load = accept;
                if (accept) begin
                    state_next = ST_RUN;
                    rnd_next   = s_op ? 4'(NR - 1) : 4'd1;
                end
            end
            ST_RUN: begin
                ctrl.step = 1'b1;
                ctrl.last = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == 4'(NR));
                if (ctrl.last) begin
                    state_next = ST_DONE;
                end else begin
                    rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                end
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            dec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            if (accept) dec_reg <= s_op;
        end
    end

    aes_round u_round (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .text_in   ({s_text_in_hi, s_text_in_lo}),
        .round_key (rd_key),
        .state_out (state_out)
    );

    // The round register holds the result while a beat waits in ST_DONE.
    assign m_valid       = (state_reg == ST_DONE);
    assign m_text_out_hi = state_out[127:64];
    assign m_text_out_lo = state_out[63:0];

endmodule

FILE: rtl/aes_round.sv
// Shared AES round datapath: one forward or inverse round per cycle while ctrl.step is set.
module aes_round
    import aes_pkg::*;
(
    input  logic         aclk,
    input  rnd_ctrl_t    ctrl,
    input  logic [127:0] text_in,
    input  logic [127:0] round_key,
    output logic [127:0] state_out
);

    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [7:0]   b   [16];
    logic [7:0]   sr  [16];
    logic [7:0]   sb  [16];
    logic [7:0]   ak  [16];
    logic [7:0]   mc  [16];
    logic [7:0]   k   [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b[i] = state_reg[127 - 8*i -: 8];
            k[i] = round_key[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctrl.dec) begin
                    sr[r + 4*((c + r) % 4)] = b[r + 4*c];
                end else begin
                    sr[r + 4*c] = b[r + 4*((c + r) % 4)];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            sb[i] = ctrl.dec ? SBOX_REV[sr[i]] : FWD_SBOX[sr[i]];
        end
        // Encryption mixes before key addition, decryption after it.
        for (int i = 0; i < 16; i++) ak[i] = ctrl.dec ? (sb[i] ^ k[i]) : sb[i];
        for (int c = 0; c < 4; c++) begin
            if (ctrl.dec) begin
                mc[4*c]   = gmul(ak[4*c],4'he) ^ gmul(ak[4*c+1],4'hb)
                          ^ gmul(ak[4*c+2],4'hd) ^ gmul(ak[4*c+3],4'h9);
                mc[4*c+1] = gmul(ak[4*c],4'h9) ^ gmul(ak[4*c+1],4'he)
                          ^ gmul(ak[4*c+2],4'hb) ^ gmul(ak[4*c+3],4'hd);
                mc[4*c+2] = gmul(ak[4*c],4'hd) ^ gmul(ak[4*c+1],4'h9)
                          ^ gmul(ak[4*c+2],4'he) ^ gmul(ak[4*c+3],4'hb);
                mc[4*c+3] = gmul(ak[4*c],4'hb) ^ gmul(ak[4*c+1],4'hd)
                          ^ gmul(ak[4*c+2],4'h9) ^ gmul(ak[4*c+3],4'he);
            end else begin
                mc[4*c]   = gmul(ak[4*c],4'h2) ^ gmul(ak[4*c+1],4'h3)
                          ^ ak[4*c+2] ^ ak[4*c+3];
                mc[4*c+1] = ak[4*c] ^ gmul(ak[4*c+1],4'h2)
                          ^ gmul(ak[4*c+2],4'h3) ^ ak[4*c+3];
                mc[4*c+2] = ak[4*c] ^ ak[4*c+1]
                          ^ gmul(ak[4*c+2],4'h2) ^ gmul(ak[4*c+3],4'h3);
                mc[4*c+3] = gmul(ak[4*c],4'h3) ^ ak[4*c+1]
                          ^ ak[4*c+2] ^ gmul(ak[4*c+3],4'h2);
            end
        end
        state_next = state_reg;
        if (ctrl.load) begin
            state_next = text_in ^ round_key;
        end else if (ctrl.step) begin
            for (int i = 0; i < 16; i++) begin
                if (ctrl.last) begin
                    state_next[127 - 8*i -: 8] = ak[i] ^ (ctrl.dec ? 8'h00 : k[i]);
                end else if (ctrl.dec) begin
                    state_next[127 - 8*i -: 8] = mc[i];
                end else begin
                    state_next[127 - 8*i -: 8] = mc[i] ^ k[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
    end

    assign state_out = state_reg;

endmodule

FILE: rtl/aes_key_sched.sv
// Round key store and iterative key expansion, one round key per cycle while busy.
module aes_key_sched
    import aes_pkg::*;
(
    input  logic         aclk,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [3:0]   rd_idx,
    output logic [127:0] rd_key,
    output logic         busy
);

    logic [127:0] store [NR + 1];
    logic [127:0] cur_reg;
    logic [127:0] cur_next;
    logic [3:0]   cnt_reg;
    logic [7:0]   rcon_reg;
    logic         busy_reg;
    logic [31:0]  t;
    logic [31:0]  w0, w1, w2, w3;

    always_comb begin
        t  = sub_word({cur_reg[23:0], cur_reg[31:24]}) ^ {rcon_reg, 24'h0};
        w0 = cur_reg[127:96] ^ t;
        w1 = cur_reg[95:64] ^ w0;
        w2 = cur_reg[63:32] ^ w1;
        w3 = cur_reg[31:0] ^ w2;
        cur_next = {w0, w1, w2, w3};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cur_reg  <= key;
            store[0] <= key;
            cnt_reg  <= 4'd1;
            rcon_reg <= 8'h01;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            cur_reg        <= cur_next;
            store[cnt_reg] <= cur_next;
            rcon_reg       <= xtime(rcon_reg);
            cnt_reg        <= cnt_reg + 4'd1;
            busy_reg       <= (cnt_reg != 4'(NR));
        end
    end

    assign rd_key = store[rd_idx];
    assign busy   = busy_reg | start;

endmodule

FILE: rtl/aes_checker.sv
// Port-level checker for the AES core, bound to the top level.
module aes_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_text_out_hi
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !m_valid)
        else $error("block not busy after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_text_out_hi))
        else $error("result dropped or changed");

endmodule

bind aes128_block_cipher aes_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_text_out_hi(m_text_out_hi)
);
